// ===== rtl/assert_macros.svh =====
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define ATOD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ATOD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/atod_pkg.sv =====
`timescale 1ns / 1ps
package atod_pkg;

  localparam int Q_W        = 24;
  localparam int SQ_W       = 48;
  localparam int MUL_W      = 28;
  localparam int DIV_W      = 49;
  localparam int DIV_CNT_W  = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 23;

  localparam int Q_MAX           = 8388607;
  localparam int Q_MIN           = -8388608;
  localparam int ONSET_MIN_COUNT = 10;

  localparam logic [SQ_W-1:0] SQ_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING_COEF   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STD_DEV_MULTIPLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_FLOOR  = 2'd2;

  localparam logic CMD_CLEAR = 1'b1;

  localparam logic signed [1:0] LVL_POS  = 2'sd1;
  localparam logic signed [1:0] LVL_ZERO = 2'sd0;
  localparam logic signed [1:0] LVL_NEG  = -2'sd1;

  // Start of a rounded division by a small positive divisor.
  typedef struct packed {
    logic            start;
    logic [SQ_W-1:0] mag;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
  } div_rsp_t;

endpackage

// ===== rtl/adaptive_threshold_onset_detector.sv =====
`timescale 1ns / 1ps
// Channel  | Signals                                            | Dir
// ---------+----------------------------------------------------+-----
// cfg      | cfg_valid, cfg_ready, cfg_index, cfg_data          | in
// in       | in_valid, in_ready, cmd, sample                    | in
// out      | out_valid, out_ready, onset_event, level_state,    | out
//          | mean_level, threshold_level                        |
//
// While the window fills and once it is full, a sample goes from its input beat to its
// output beat through two passes of the rounded divider, the square root, and steps on
// the shared multiplier and the ring.
// The first sample after reset or clear skips both divider passes.
// A clear command raises its result beat in the cycle after its input beat.
// Synchronous reset restores the register defaults and clears all statistics.
// A new input beat is taken only once the previous result beat has gone out.
// Configuration beats are always taken, and are meant for an idle block.
`include "assert_macros.svh"
module adaptive_threshold_onset_detector import atod_pkg::*; #(
  parameter int WINDOW = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  cmd,
  input  logic signed [15:0]    sample,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [1:0]     onset_event,
  output logic signed [1:0]     level_state,
  output logic signed [23:0]    mean_level,
  output logic signed [23:0]    threshold_level
);

  localparam int PTR_W = $clog2(WINDOW);
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam logic [SQ_W-1:0] VAR_LIMIT = SQ_W'(SQ_MAX / WINDOW);

  // The sequencer walks the smoothing filter, the statistics update, the
  // square root and the threshold decision through one multiplier, one
  // divider and one square-root step.
  typedef enum logic [4:0] {
    ST_IDLE, ST_SM_A, ST_SM_B, ST_SM_C,
    ST_WU_DIV, ST_WU_MUL, ST_WU_ACC, ST_WU_VAR,
    ST_SL_DIV, ST_SL_MUL, ST_SL_ACC, ST_SL_VAR,
    ST_WIN_LO, ST_WIN_HI, ST_WIN_SUM,
    ST_SQ_INIT, ST_SQRT, ST_THR, ST_FIN, ST_OUT
  } state_t;

  state_t state;

  // Configuration registers.
  logic [16:0]            smoothing_coef;
  logic [15:0]            std_dev_multiple;
  logic [22:0]            threshold_floor;

  // Detector statistics.
  logic signed [Q_W-1:0]  smoothed;
  logic [PTR_W-1:0]       wp;
  logic [CNT_W-1:0]       count;
  logic signed [Q_W-1:0]  mean;
  logic [SQ_W-1:0]        wss_warm;
  logic [SQ_W-1:0]        wss_win;
  logic [SQ_W-1:0]        variance;
  logic signed [1:0]      prev_level;

  // Working registers of the current sample.
  logic signed [Q_W-1:0]     xq;
  logic signed [Q_W-1:0]     v;
  logic signed [Q_W-1:0]     oldest;
  logic signed [25:0]        diff;
  logic signed [25:0]        nm;
  logic signed [2*MUL_W-1:0] acc;
  logic signed [2*MUL_W-1:0] prod;
  logic [SQ_W-1:0]           sq_v;
  logic [SQ_W:0]             sq_r;
  logic [SQ_W-1:0]           sq_b;

  // Divider request.
  logic                   div_start;
  logic [SQ_W-1:0]        div_mag;
  logic                   div_neg;
  logic [CNT_W-1:0]       div_den;
  div_req_t               div_req;
  div_rsp_t               div_rsp;

  logic [Q_W-1:0]         ring_rdata;

  // Combinational datapath.
  logic [16:0]               one_minus_c;
  logic signed [MUL_W-1:0]   mul_a;
  logic signed [MUL_W-1:0]   mul_b;
  logic signed [2*MUL_W-1:0] mul_p;
  logic signed [56:0]        sm_sum;
  logic signed [Q_W-1:0]     s_new;
  logic                      warming;
  logic signed [25:0]        diff_new;
  logic [25:0]               diff_mag;
  logic signed [DIV_W:0]     q_s;
  logic signed [25:0]        nm_new;
  logic signed [Q_W-1:0]     nm_sat;
  logic [SQ_W-1:0]           wss_base;
  logic signed [57:0]        wss_sum;
  logic [SQ_W-1:0]           wss_sat;
  logic [SQ_W:0]             sq_t;
  logic                      sq_ge;
  logic [40:0]               thr_sum;
  logic [32:0]               thr_raw;
  logic [32:0]               thr;
  logic [24:0]               ax;
  logic signed [34:0]        excess;
  logic signed [34:0]        tl_sum;
  logic signed [Q_W-1:0]     tl_sat;
  logic signed [1:0]         lvl_new;
  logic signed [1:0]         evt_new;

  always_comb begin
    one_minus_c = 17'h10000 - smoothing_coef;
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_SM_A: begin
        mul_a = MUL_W'(xq);
        mul_b = MUL_W'($signed({1'b0, one_minus_c}));
      end
      ST_SM_B: begin
        mul_a = MUL_W'(smoothed);
        mul_b = MUL_W'($signed({1'b0, smoothing_coef}));
      end
      ST_WU_MUL: begin
        mul_a = MUL_W'(diff);
        mul_b = MUL_W'(v) - MUL_W'(nm);
      end
      ST_SL_MUL: begin
        mul_a = MUL_W'(v) + MUL_W'(oldest) - MUL_W'(mean) - MUL_W'(nm);
        mul_b = MUL_W'(diff);
      end
      ST_WIN_LO: begin
        mul_a = MUL_W'($signed({1'b0, variance[23:0]}));
        mul_b = MUL_W'(WINDOW);
      end
      ST_WIN_HI: begin
        mul_a = MUL_W'($signed({1'b0, variance[47:24]}));
        mul_b = MUL_W'(WINDOW);
      end
      ST_THR: begin
        mul_a = MUL_W'($signed({1'b0, sq_r[23:0]}));
        mul_b = MUL_W'($signed({1'b0, std_dev_multiple}));
      end
      default: begin
      end
    endcase
    mul_p = mul_a * mul_b;

    // Rounded smoothing result, ties toward plus infinity.
    sm_sum = 57'(acc) + 57'(prod) + 57'sd32768;
    s_new  = $signed(sm_sum[39:16]);

    warming  = count < CNT_W'(WINDOW);
    diff_new = warming ? (26'(s_new) - 26'(mean)) : (26'(s_new) - 26'(oldest));
    diff_mag = diff_new[25] ? 26'(-diff_new) : 26'(diff_new);

    q_s    = div_neg ? -$signed({1'b0, div_rsp.quot}) : $signed({1'b0, div_rsp.quot});
    nm_new = 26'(mean) + $signed(q_s[25:0]);
    if (nm > 26'(Q_MAX)) begin
      nm_sat = Q_W'(Q_MAX);
    end else if (nm < 26'(Q_MIN)) begin
      nm_sat = Q_W'(Q_MIN);
    end else begin
      nm_sat = nm[Q_W-1:0];
    end

    wss_base = (state == ST_WU_ACC) ? wss_warm : wss_win;
    wss_sum  = $signed({10'b0, wss_base}) + 58'(prod);
    if (wss_sum < 0) begin
      wss_sat = '0;
    end else if (wss_sum > $signed({10'b0, SQ_MAX})) begin
      wss_sat = SQ_MAX;
    end else begin
      wss_sat = wss_sum[SQ_W-1:0];
    end

    sq_t  = sq_r + {1'b0, sq_b};
    sq_ge = {1'b0, sq_v} >= sq_t;

    // Threshold from the registered product std_dev * multiple.
    thr_sum = prod[40:0] + 41'd128;
    thr_raw = thr_sum[40:8];
    thr     = (thr_raw < {10'b0, threshold_floor}) ? {10'b0, threshold_floor} : thr_raw;

    ax      = xq[Q_W-1] ? 25'(-(25'(xq))) : 25'(xq);
    excess  = $signed({10'b0, ax}) - 35'(mean);
    if (excess > $signed({2'b0, thr})) begin
      lvl_new = (xq > mean) ? LVL_POS : LVL_NEG;
    end else begin
      lvl_new = LVL_ZERO;
    end
    if (int'(count) > ONSET_MIN_COUNT && lvl_new != LVL_ZERO && lvl_new != prev_level) begin
      evt_new = lvl_new;
    end else begin
      evt_new = LVL_ZERO;
    end

    tl_sum = 35'(mean) + $signed({2'b0, thr});
    if (tl_sum > 35'(Q_MAX)) begin
      tl_sat = Q_W'(Q_MAX);
    end else if (tl_sum < 35'(Q_MIN)) begin
      tl_sat = Q_W'(Q_MIN);
    end else begin
      tl_sat = tl_sum[Q_W-1:0];
    end
  end

  assign div_req.start = div_start;
  assign div_req.mag   = div_mag;

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      smoothing_coef   <= 17'd32768;
      std_dev_multiple <= 16'd896;
      threshold_floor  <= '0;
      smoothed         <= '0;
      wp               <= '0;
      count            <= '0;
      mean             <= '0;
      wss_warm         <= '0;
      wss_win          <= '0;
      variance         <= '0;
      prev_level       <= LVL_ZERO;
      div_start        <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      prod      <= mul_p;
      div_start <= 1'b0;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SMOOTHING_COEF: begin
            smoothing_coef <= (cfg_data[16:0] > 17'h10000) ? 17'h10000 : cfg_data[16:0];
          end
          CFG_STD_DEV_MULTIPLE: std_dev_multiple <= cfg_data[15:0];
          CFG_THRESHOLD_FLOOR:  threshold_floor  <= cfg_data[22:0];
          default: begin
          end
        endcase
      end

      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            if (cmd == CMD_CLEAR) begin
              smoothed        <= '0;
              wp              <= '0;
              count           <= '0;
              mean            <= '0;
              wss_warm        <= '0;
              wss_win         <= '0;
              variance        <= '0;
              prev_level      <= LVL_ZERO;
              onset_event     <= LVL_ZERO;
              level_state     <= LVL_ZERO;
              mean_level      <= '0;
              threshold_level <= $signed({1'b0, threshold_floor});
              out_valid       <= 1'b1;
              state           <= ST_OUT;
            end else begin
              xq    <= {sample, 8'b0};
              state <= ST_SM_A;
            end
          end
        end
        ST_SM_A: state <= ST_SM_B;
        ST_SM_B: begin
          acc    <= prod;
          oldest <= $signed(ring_rdata);
          state  <= ST_SM_C;
        end
        ST_SM_C: begin
          smoothed <= s_new;
          v        <= s_new;
          wp       <= (wp == PTR_W'(WINDOW - 1)) ? '0 : wp + 1'b1;
          diff     <= diff_new;
          div_mag  <= SQ_W'(diff_mag);
          div_neg  <= diff_new[25];
          if (warming) begin
            count <= count + 1'b1;
            if (count == '0) begin
              mean     <= s_new;
              wss_warm <= '0;
              state    <= ST_WIN_LO;
            end else begin
              div_start <= 1'b1;
              div_den   <= count + 1'b1;
              state     <= ST_WU_DIV;
            end
          end else begin
            div_start <= 1'b1;
            div_den   <= CNT_W'(WINDOW);
            state     <= ST_SL_DIV;
          end
        end
        ST_WU_DIV: begin
          if (div_rsp.done) begin
            nm    <= nm_new;
            state <= ST_WU_MUL;
          end
        end
        ST_WU_MUL: state <= ST_WU_ACC;
        ST_WU_ACC: begin
          wss_warm  <= wss_sat;
          mean      <= nm_sat;
          div_start <= 1'b1;
          div_mag   <= wss_sat;
          div_neg   <= 1'b0;
          div_den   <= count - 1'b1;
          state     <= ST_WU_VAR;
        end
        ST_WU_VAR: begin
          if (div_rsp.done) begin
            variance <= div_rsp.quot[SQ_W-1:0];
            state    <= ST_WIN_LO;
          end
        end
        ST_WIN_LO: begin
          if (variance > VAR_LIMIT) begin
            wss_win <= SQ_MAX;
            state   <= ST_SQ_INIT;
          end else begin
            state <= ST_WIN_HI;
          end
        end
        ST_WIN_HI: begin
          acc   <= prod;
          state <= ST_WIN_SUM;
        end
        ST_WIN_SUM: begin
          wss_win <= acc[SQ_W-1:0] + {prod[23:0], 24'b0};
          state   <= ST_SQ_INIT;
        end
        ST_SL_DIV: begin
          if (div_rsp.done) begin
            nm    <= nm_new;
            state <= ST_SL_MUL;
          end
        end
        ST_SL_MUL: state <= ST_SL_ACC;
        ST_SL_ACC: begin
          wss_win   <= wss_sat;
          mean      <= nm_sat;
          div_start <= 1'b1;
          div_mag   <= wss_sat;
          div_neg   <= 1'b0;
          div_den   <= CNT_W'(WINDOW);
          state     <= ST_SL_VAR;
        end
        ST_SL_VAR: begin
          if (div_rsp.done) begin
            variance <= div_rsp.quot[SQ_W-1:0];
            state    <= ST_SQ_INIT;
          end
        end
        ST_SQ_INIT: begin
          sq_v  <= variance;
          sq_r  <= '0;
          sq_b  <= SQ_W'(1) << (SQ_W - 2);
          state <= ST_SQRT;
        end
        ST_SQRT: begin
          if (sq_ge) begin
            sq_v <= sq_v - sq_t[SQ_W-1:0];
            sq_r <= (sq_r >> 1) + {1'b0, sq_b};
          end else begin
            sq_r <= sq_r >> 1;
          end
          sq_b <= sq_b >> 2;
          if (sq_b[0]) begin
            state <= ST_THR;
          end
        end
        ST_THR: state <= ST_FIN;
        ST_FIN: begin
          prev_level      <= lvl_new;
          onset_event     <= evt_new;
          level_state     <= lvl_new;
          mean_level      <= mean;
          threshold_level <= tl_sat;
          out_valid       <= 1'b1;
          state           <= ST_OUT;
        end
        ST_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // The window ring's read data is used only once it has been filled since the last clear,
  // so its contents need no reset.
  atod_ram #(
    .WIDTH(Q_W),
    .DEPTH(WINDOW)
  ) u_ring (
    .clk  (clk),
    .we   (state == ST_SM_C),
    .waddr(wp),
    .wdata(s_new),
    .raddr(wp),
    .rdata(ring_rdata)
  );

  atod_rdiv #(
    .DEN_W(CNT_W)
  ) u_rdiv (
    .clk(clk),
    .rst(rst),
    .req(div_req),
    .den(div_den),
    .rsp(div_rsp)
  );

  // A result waiting at the output never coexists with an open input.
  `ATOD_ASSERT_ALWAYS(a_no_overlap, rst || !(in_ready && out_valid), "input open while result pending")
  // An accepted sample keeps the input closed on the next cycle.
  `ATOD_ASSERT(a_busy_after_beat, in_valid && in_ready |=> !in_ready, "input open after beat")
  // An onset always agrees with the level reported with it.
  `ATOD_ASSERT(a_event_level, out_valid && onset_event != LVL_ZERO |-> onset_event == level_state,
    "onset disagrees with level")
  // The level never takes the unused code.
  `ATOD_ASSERT(a_level_code, out_valid |-> level_state != 2'b10, "level out of range")

endmodule

// ===== rtl/atod_ram.sv =====
`timescale 1ns / 1ps
module atod_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/atod_rdiv.sv =====
`timescale 1ns / 1ps
module atod_rdiv import atod_pkg::*; #(
  parameter int DEN_W = 7
) (
  input  logic             clk,
  input  logic             rst,
  input  div_req_t         req,
  input  logic [DEN_W-1:0] den,
  output div_rsp_t         rsp
);

  // Restoring division of (mag + den/2) by den, one quotient bit per cycle.
  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_W-1:0]     work;
  logic [DEN_W-1:0]     rem;
  logic [DEN_W:0]       rem_sh;
  logic [DEN_W:0]       rem_sub;
  logic                 ge;

  always_comb begin
    rem_sh  = {rem, work[DIV_W-1]};
    ge      = rem_sh >= {1'b0, den};
    rem_sub = rem_sh - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        work <= {1'b0, req.mag} + DIV_W'(den >> 1);
      end else if (busy) begin
        rem  <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        work <= {work[DIV_W-2:0], ge};
        cnt  <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = work;

endmodule

// ===== dv/adaptive_threshold_onset_detector_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the onset detector. A predictor in this module tracks the
// smoothing filter, the moving statistics and the level history. It pushes one expected
// result per accepted input beat, and a monitor checks the output beats in order.
module adaptive_threshold_onset_detector_test;
  import atod_pkg::*;

  localparam int WINDOW = 64;
  localparam int STALL_MAX = 14;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_ITEMS = 1600;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 2'd3;
  localparam longint SQ_LIMIT = 64'd281474976710655;
  localparam logic CMD_SAMPLE = 1'b0;

  // One result beat, as the predictor expects it.
  typedef struct packed {
    logic signed [1:0]  onset;
    logic signed [1:0]  level;
    logic signed [23:0] mean;
    logic signed [23:0] thresh;
  } onset_result_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic                  cmd;
  logic signed [15:0]    sample;
  logic                  out_valid;
  logic                  out_ready;
  logic signed [1:0]     onset_event;
  logic signed [1:0]     level_state;
  logic signed [23:0]    mean_level;
  logic signed [23:0]    threshold_level;

  adaptive_threshold_onset_detector #(.WINDOW(WINDOW)) u_top (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd), .sample(sample),
    .out_valid(out_valid), .out_ready(out_ready), .onset_event(onset_event),
    .level_state(level_state), .mean_level(mean_level), .threshold_level(threshold_level)
  );

  // Predictor copy of the configuration registers.
  longint coef_q16;
  longint sd_multiple;
  longint floor_q8;

  // Predictor copy of the filter and statistics.
  longint smooth_q8;
  longint ring_q8 [WINDOW];
  int     wr_ptr;
  int     seen_count;
  longint mean_q8;
  longint warm_sumsq;
  longint slide_sumsq;
  longint variance_q16;
  int     last_level;

  onset_result_t pending_results[$];
  int  mismatch_count;
  int  beats_checked;
  int  samples_sent;
  int  clears_sent;
  int  onsets_seen;
  int  idle_cycles;
  bit  no_idle;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint clamp_range(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Division by a positive divisor, rounded to nearest with ties away from zero.
  function automatic longint round_div(longint a, longint d);
    longint m;
    longint q;
    m = a < 0 ? -a : a;
    q = (m + d / 2) / d;
    return a < 0 ? -q : q;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 48;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic void clear_stats();
    smooth_q8 = 0;
    foreach (ring_q8[i]) ring_q8[i] = 0;
    wr_ptr = 0;
    seen_count = 0;
    mean_q8 = 0;
    warm_sumsq = 0;
    slide_sumsq = 0;
    variance_q16 = 0;
    last_level = 0;
  endfunction

  function automatic void apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    longint c;
    case (idx)
      CFG_SMOOTHING_COEF: begin
        c = longint'(val[16:0]);
        coef_q16 = c > 65536 ? 65536 : c;
      end
      CFG_STD_DEV_MULTIPLE: sd_multiple = longint'(val[15:0]);
      CFG_THRESHOLD_FLOOR:  floor_q8 = longint'(val[22:0]);
      default: ;
    endcase
  endfunction

  // Works out the result beat of one input beat and advances the predictor state.
  function automatic onset_result_t detect_step(logic op, logic signed [15:0] smp);
    onset_result_t r;
    longint xq, t, v, oldest, nm, d, thr, ax, tl;
    longint unsigned sd;
    int lvl;
    int ev;
    if (op == CMD_CLEAR) begin
      clear_stats();
      r.onset = LVL_ZERO;
      r.level = LVL_ZERO;
      r.mean = '0;
      r.thresh = floor_q8[23:0];
      return r;
    end
    xq = longint'(smp) * 256;
    t = xq * (65536 - coef_q16) + smooth_q8 * coef_q16;
    smooth_q8 = ((t + (64'sd1 <<< 40) + 32768) >>> 16) - (64'sd1 <<< 24);
    v = smooth_q8;
    oldest = ring_q8[wr_ptr];
    ring_q8[wr_ptr] = v;
    wr_ptr = (wr_ptr + 1) % WINDOW;
    if (seen_count < WINDOW) begin
      // Warm-up: Welford update with divisor n-1.
      seen_count++;
      if (seen_count == 1) begin
        mean_q8 = v;
        warm_sumsq = 0;
      end else begin
        d = v - mean_q8;
        nm = mean_q8 + round_div(d, seen_count);
        warm_sumsq = clamp_range(warm_sumsq + d * (v - nm), 0, SQ_LIMIT);
        mean_q8 = clamp_range(nm, Q_MIN, Q_MAX);
        variance_q16 = round_div(warm_sumsq, seen_count - 1);
      end
      slide_sumsq = variance_q16 > SQ_LIMIT / WINDOW ? SQ_LIMIT : variance_q16 * WINDOW;
    end else begin
      // Full window: slide the sums, dropping the oldest entry of the ring.
      nm = mean_q8 + round_div(v - oldest, WINDOW);
      slide_sumsq = clamp_range(slide_sumsq + (v + oldest - mean_q8 - nm) * (v - oldest),
                                0, SQ_LIMIT);
      variance_q16 = round_div(slide_sumsq, WINDOW);
      mean_q8 = clamp_range(nm, Q_MIN, Q_MAX);
    end
    sd = int_sqrt(longint'(variance_q16));
    thr = longint'((sd * sd_multiple + 128) >> 8);
    if (thr < floor_q8) thr = floor_q8;
    ax = xq < 0 ? -xq : xq;
    lvl = 0;
    if (ax - mean_q8 > thr) lvl = xq > mean_q8 ? 1 : -1;
    ev = (seen_count > ONSET_MIN_COUNT && lvl != 0 && lvl != last_level) ? lvl : 0;
    last_level = lvl;
    tl = clamp_range(mean_q8 + thr, Q_MIN, Q_MAX);
    r.onset = ev == 1 ? LVL_POS : (ev == -1 ? LVL_NEG : LVL_ZERO);
    r.level = lvl == 1 ? LVL_POS : (lvl == -1 ? LVL_NEG : LVL_ZERO);
    r.mean = mean_q8[23:0];
    r.thresh = tl[23:0];
    return r;
  endfunction

  // Sends one input beat after a random gap; the expectation is pushed at acceptance.
  task automatic send_item(logic op, logic signed [15:0] smp);
    int gap;
    gap = no_idle ? 0 : $urandom_range(STALL_MAX);
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid = 1'b1;
    cmd = op;
    sample = smp;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(detect_step(op, smp));
    if (op == CMD_CLEAR) clears_sent++;
    else samples_sent++;
  endtask

  // Registers change only on an idle block, so drain every pending result first.
  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    in_valid = 1'b0;
    wait (pending_results.size() == 0);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    apply_register(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic write_all(logic [CFG_DATA_W-1:0] coef, logic [CFG_DATA_W-1:0] mult,
                           logic [CFG_DATA_W-1:0] flr);
    write_register(CFG_SMOOTHING_COEF, coef);
    write_register(CFG_STD_DEV_MULTIPLE, mult);
    write_register(CFG_THRESHOLD_FLOOR, flr);
  endtask

  // Field extremes, both commands, and a clear that lands mid-run.
  task automatic test_field_extremes();
    send_item(CMD_SAMPLE, 16'sh7fff);
    send_item(CMD_SAMPLE, -16'sh8000);
    send_item(CMD_SAMPLE, 16'sd0);
    send_item(CMD_SAMPLE, -16'sd1);
    send_item(CMD_SAMPLE, 16'sd1);
    send_item(CMD_CLEAR, 16'sh5a5a);
    send_item(CMD_SAMPLE, -16'sh8000);
    send_item(CMD_CLEAR, 16'sd0);
  endtask

  // A quiet stretch past the onset count, then a rising and a falling spike.
  task automatic test_onset_pair();
    repeat (12) send_item(CMD_SAMPLE, 16'($urandom_range(4)) - 16'sd2);
    send_item(CMD_SAMPLE, 16'sd20000);
    send_item(CMD_SAMPLE, -16'sd20000);
    send_item(CMD_SAMPLE, 16'sd0);
  endtask

  // Extreme register values: a coefficient above one, zero and full multiples,
  // and a floor so high that the threshold saturates. The spare index is also hit.
  task automatic test_register_extremes();
    write_all(23'h1ffff, 23'd0, 23'd0);
    write_register(CFG_SPARE_INDEX, 23'h7fffff);
    repeat (6) send_item(CMD_SAMPLE, 16'($urandom));
    write_all(23'h7e0000, 23'hffff, 23'h7fffff);
    repeat (6) send_item(CMD_SAMPLE, 16'($urandom));
    send_item(CMD_CLEAR, 16'($urandom));
    write_all(23'd65536, 23'd896, 23'd0);
    repeat (4) send_item(CMD_SAMPLE, 16'($urandom));
    write_all(23'd0, 23'd256, 23'd0);
    send_item(CMD_CLEAR, 16'sd0);
  endtask

  // Random phases. Most samples are low noise around a drifting base with sparse
  // spikes, which drives the statistics through warm-up into the sliding window
  // and produces onsets; the rest are raw full-range samples and rare clears.
  task automatic test_random_phases();
    int phase;
    int i;
    int kind;
    int base;
    int noise;
    logic signed [15:0] smp;
    for (phase = 0; phase < 8; phase++) begin
      no_idle = (phase % 4 == 3);
      case (phase)
        0: write_all(23'd32768, 23'd896, 23'd0);
        1: write_all(23'd0, 23'd512, 23'd256);
        2: write_all(23'd65536, 23'd1024, 23'd0);
        default: write_all(23'($urandom_range(70000)), 23'($urandom_range(2048)),
                           23'($urandom_range(1) ? $urandom_range(8192) : $urandom));
      endcase
      base = $urandom_range(2000) - 1000;
      noise = 1 << $urandom_range(10);
      for (i = 0; i < RANDOM_ITEMS / 8; i++) begin
        kind = $urandom_range(99);
        if (kind == 0) begin
          send_item(CMD_CLEAR, 16'($urandom));
        end else if (kind < 8) begin
          send_item(CMD_SAMPLE, 16'($urandom));
        end else if (kind < 16) begin
          smp = 16'($urandom_range(1) ? $urandom_range(32767, 8000)
                                      : -$urandom_range(32768, 8000));
          send_item(CMD_SAMPLE, smp);
        end else begin
          if (kind == 99) base = $urandom_range(8000) - 4000;
          send_item(CMD_SAMPLE, 16'(base + $urandom_range(noise) - noise / 2));
        end
      end
    end
    no_idle = 1'b0;
  endtask

  // Result side: a random stall before each beat.
  initial begin
    int stall;
    out_ready = 1'b0;
    @(negedge clk);
    wait (!rst);
    forever begin
      stall = no_idle ? 0 : $urandom_range(STALL_MAX);
      repeat (stall) begin
        @(negedge clk);
        out_ready = 1'b0;
      end
      @(negedge clk);
      out_ready = 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  always @(posedge clk) begin
    onset_result_t want;
    if (!rst && out_valid && out_ready) begin
      beats_checked++;
      if (onset_event != 2'sd0) onsets_seen++;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("tb: result beat with nothing pending");
      end else begin
        want = pending_results.pop_front();
        if (onset_event !== want.onset || level_state !== want.level ||
            mean_level !== want.mean || threshold_level !== want.thresh) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("tb: beat %0d expected ev %0d lvl %0d mean %0d thr %0d, got %0d %0d %0d %0d",
                     beats_checked, want.onset, want.level, want.mean, want.thresh,
                     onset_event, level_state, mean_level, threshold_level);
        end
      end
    end
  end

  // Watchdog: too long without any accepted beat on any channel ends the run.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    cmd = CMD_SAMPLE;
    sample = '0;
    no_idle = 1'b0;
    mismatch_count = 0;
    beats_checked = 0;
    samples_sent = 0;
    clears_sent = 0;
    onsets_seen = 0;
    coef_q16 = 32768;
    sd_multiple = 896;
    floor_q8 = 0;
    clear_stats();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_field_extremes();
    test_onset_pair();
    test_register_extremes();
    test_random_phases();

    @(negedge clk);
    in_valid = 1'b0;
    wait (pending_results.size() == 0);
    repeat (200) @(posedge clk);
    $display("tb: %0d samples and %0d clears sent, %0d result beats checked, %0d onsets",
             samples_sent, clears_sent, beats_checked, onsets_seen);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: %0d mismatches", mismatch_count);
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/atod_pkg.sv
rtl/atod_ram.sv
rtl/atod_rdiv.sv
rtl/adaptive_threshold_onset_detector.sv
dv/adaptive_threshold_onset_detector_test.sv
